// ===== design/hpm_pkg.sv =====
// shared constants and types of the hyphenation pattern matcher
package hpm_pkg;

    localparam int MAX_WORD    = 32;
    localparam int MAX_PATTERN = 8;
    localparam int TABLE_DEPTH = 4096;

    localparam int SYM_W   = 16;
    localparam int PRI_W   = 4;
    localparam int PLEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int WLEN_W  = $clog2(MAX_WORD + 2);

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_PATTERN = 2'd1;
    localparam logic [1:0] ACT_WORD    = 2'd2;

    localparam logic [SYM_W-1:0] SYM_DIGIT0 = 16'h0030;
    localparam logic [SYM_W-1:0] SYM_DIGIT9 = 16'h0039;

    typedef struct packed {
        logic [PLEN_W-1:0]                  len;
        logic [MAX_PATTERN:0][PRI_W-1:0]    pri;
        logic [MAX_PATTERN-1:0][SYM_W-1:0]  sym;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_wr;

endpackage

// ===== design/hpm_table.sv =====
// pattern table memory, one write port and one registered read port
module hpm_table (
    input  logic                 i_clk,
    input  hpm_pkg::t_wr         i_wr,
    input  logic                 i_rd_en,
    input  logic [hpm_pkg::ADDR_W-1:0] i_rd_addr,
    output hpm_pkg::t_entry      o_rd_data
);
    import hpm_pkg::*;

    t_entry r_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== design/hpm_asm.sv =====
// pattern assembly and pattern count
module hpm_asm (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [1:0]                 i_action,
    input  logic [hpm_pkg::SYM_W-1:0]  i_symbol,
    input  logic                       i_last,
    output hpm_pkg::t_wr               o_wr,
    output logic [hpm_pkg::CNT_W-1:0]  o_count
);
    import hpm_pkg::*;

    logic [MAX_PATTERN-1:0][SYM_W-1:0] r_let, n_let;
    logic [MAX_PATTERN:0][PRI_W-1:0]   r_pri, n_pri;
    logic [PLEN_W-1:0]                 r_alen, n_alen;
    logic                              r_ovf, n_ovf;
    logic [CNT_W-1:0]                  r_count, n_count;
    logic                              digit;

    assign digit = (i_symbol >= SYM_DIGIT0) && (i_symbol <= SYM_DIGIT9);

    always_comb begin
        n_let   = r_let;
        n_pri   = r_pri;
        n_alen  = r_alen;
        n_ovf   = r_ovf;
        n_count = r_count;
        o_wr    = '0;
        if (i_take && i_action == ACT_CLEAR) begin
            n_count = '0;
            n_pri   = '0;
            n_alen  = '0;
            n_ovf   = 1'b0;
        end else if (i_take && i_action == ACT_PATTERN) begin
            if (digit && !r_ovf) begin
                n_pri[r_alen] = i_symbol[PRI_W-1:0];
            end else if (!digit && !r_ovf) begin
                if (r_alen >= PLEN_W'(MAX_PATTERN)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_let[r_alen[$clog2(MAX_PATTERN)-1:0]] = i_symbol;
                    n_alen = r_alen + 1'b1;
                    n_pri[n_alen] = '0;
                end
            end
            if (i_last) begin
                o_wr.en   = !n_ovf && (r_count < CNT_W'(TABLE_DEPTH));
                o_wr.addr = r_count[ADDR_W-1:0];
                o_wr.data = '{len: n_alen, pri: n_pri, sym: n_let};
                if (o_wr.en) begin
                    n_count = r_count + 1'b1;
                end
                n_pri  = '0;
                n_alen = '0;
                n_ovf  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_let <= n_let;
        if (!i_rst_n) begin
            r_pri   <= '0;
            r_alen  <= '0;
            r_ovf   <= 1'b0;
            r_count <= '0;
        end else begin
            r_pri   <= n_pri;
            r_alen  <= n_alen;
            r_ovf   <= n_ovf;
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

// ===== design/hyphenation_pattern_matcher_core.sv =====
// hyphenation pattern matcher top level: word buffer, table walk and result output
// a word item without last, a pattern item and a clear item are taken without stalling
// after the last word character: a table walk at successive start positions over the
// single read port of the pattern table, then a drain of the gaps, or the drain alone
// when there is no walk, then one result per cycle unless stalled
// input is stalled until the last result of the word is registered
// synchronous active-low reset empties the table count, assembly and word state
module hyphenation_pattern_matcher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_symbol,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_gap_position,
    output logic        o_hyphen_allowed,
    output logic        o_final_gap,
    output logic        o_truncated
);
    import hpm_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_LOOK, S_LWAIT, S_DRAIN, S_EMIT} t_state;

    t_state                     r_state;
    logic                       take;
    t_wr                        wr;
    logic [CNT_W-1:0]           count;
    t_entry                     rd_data;
    logic [ADDR_W-1:0]          r_p;
    logic                       r_pend;
    logic [MAX_WORD-1:0][SYM_W-1:0] r_word;
    logic [MAX_WORD:0][PRI_W-1:0]   r_gap, n_gap, upd;
    logic [MAX_WORD:0]          r_hyph;
    logic [WLEN_W-1:0]          r_wlen, r_sc, rem;
    logic                       r_wovf;
    logic [4:0]                 r_ei;
    logic [MAX_PATTERN:0]       r_seen;
    logic                       mis, hit, shift;

    assign o_stall = (r_state != S_IDLE);
    assign take    = i_valid && !o_stall;

    hpm_asm u_asm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_action (i_action),
        .i_symbol (i_symbol),
        .i_last   (i_last),
        .o_wr     (wr),
        .o_count  (count)
    );

    hpm_table u_table (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (r_state == S_LOOK),
        .i_rd_addr (r_p),
        .o_rd_data (rd_data)
    );

    // compare the stored pattern against the word window at the current start
    // only the earliest matching pattern of each length counts at one start
    assign rem = r_wlen - r_sc;
    always_comb begin
        mis = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((PLEN_W'(i) < rd_data.len) && (rd_data.sym[i] != r_word[i])) begin
                mis = 1'b1;
            end
        end
        hit = r_pend && (rd_data.len != '0) && (WLEN_W'(rd_data.len) <= rem) && !mis
              && !r_seen[rd_data.len];
    end

    assign shift = (r_state == S_LWAIT) || (r_state == S_DRAIN);

    always_comb begin
        upd = r_gap;
        for (int i = 0; i <= MAX_PATTERN; i++) begin
            if (hit && (PLEN_W'(i) <= rd_data.len) && (upd[i] < rd_data.pri[i])) begin
                upd[i] = rd_data.pri[i];
            end
        end
        n_gap = upd;
        if (shift) begin
            n_gap = {PRI_W'(0), upd[MAX_WORD:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_action == ACT_WORD && r_wlen < WLEN_W'(MAX_WORD)) begin
            r_word[r_wlen[$clog2(MAX_WORD)-1:0]] <= i_symbol;
        end else if (r_state == S_LWAIT) begin
            r_word <= {SYM_W'(0), r_word[MAX_WORD-1:1]};
        end
        if (shift) begin
            r_hyph[r_sc] <= upd[0][0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p     <= '0;
            r_pend  <= 1'b0;
            r_gap   <= '0;
            r_wlen  <= '0;
            r_wovf  <= 1'b0;
            r_sc    <= '0;
            r_ei    <= '0;
            r_seen  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_gap  <= n_gap;
            r_pend <= (r_state == S_LOOK);
            if (r_state == S_IDLE || r_state == S_LWAIT) begin
                r_seen <= '0;
            end else if (hit) begin
                r_seen[rd_data.len] <= 1'b1;
            end
            if (o_valid && !i_stall && r_state != S_EMIT) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take && i_action == ACT_WORD) begin
                        if (r_wlen < WLEN_W'(MAX_WORD)) begin
                            r_wlen <= r_wlen + 1'b1;
                        end else begin
                            r_wovf <= 1'b1;
                        end
                        if (i_last) begin
                            r_sc <= '0;
                            r_p  <= '0;
                            if (count != '0 && r_wlen >= WLEN_W'(2)) begin
                                r_state <= S_LOOK;
                            end else begin
                                r_state <= S_DRAIN;
                            end
                        end
                    end
                end
                S_LOOK: begin
                    if (CNT_W'(r_p) + 1'b1 == count) begin
                        r_state <= S_LWAIT;
                    end else begin
                        r_p <= r_p + 1'b1;
                    end
                end
                S_LWAIT: begin
                    r_sc <= r_sc + 1'b1;
                    r_p  <= '0;
                    if (r_sc + WLEN_W'(3) == r_wlen) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_state <= S_LOOK;
                    end
                end
                S_DRAIN: begin
                    r_sc <= r_sc + 1'b1;
                    if (r_sc == r_wlen) begin
                        r_ei <= '0;
                        if (r_wlen >= WLEN_W'(2)) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_wlen  <= '0;
                            r_wovf  <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMIT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid          <= 1'b1;
                        o_gap_position   <= r_ei;
                        o_hyphen_allowed <= (count != '0) && r_hyph[{1'b0, r_ei} + 6'd1];
                        o_final_gap      <= ({1'b0, r_ei} + 6'd2 == r_wlen);
                        o_truncated      <= r_wovf;
                        r_ei             <= r_ei + 1'b1;
                        if ({1'b0, r_ei} + 6'd2 == r_wlen) begin
                            r_wlen  <= '0;
                            r_wovf  <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(r_state) == S_LOOK)
        else $error("table data without a read");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CNT_W'(TABLE_DEPTH))
        else $error("pattern count beyond table depth");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_wlen >= WLEN_W'(2)))
        else $error("emitting a word without gaps");

endmodule
